/* rtl/timed_step_pulse_scheduler_unit_macros.svh */
// Assertion macros for the timed step pulse scheduler checker.
// Needs a clk and an arst_n signal in the scope where a macro is used.
`ifndef TIMED_STEP_PULSE_SCHEDULER_UNIT_MACROS_SVH
`define TIMED_STEP_PULSE_SCHEDULER_UNIT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define TSPS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define TSPS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/tsps_pkg.sv */
// Shared types and constants of the timed step pulse scheduler.
// No dependencies; used by tsps_period and the top level.
`default_nettype none

package tsps_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF     = 64;
	localparam int unsigned TIMER_MAX_COUNT_DEF = 65536;

	localparam int unsigned PREP_W    = 13;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_W     = 13;

	// Item kinds.
	localparam logic [1:0] KIND_PUSH   = 2'd0;
	localparam logic [1:0] KIND_TIMER  = 2'd1;
	localparam logic [1:0] KIND_RESET  = 2'd2;
	localparam logic [1:0] KIND_SETPOS = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_DIR_INV = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PREP    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH   = 2'd2;

	localparam logic [PREP_W-1:0] PREP_RESET  = 13'd20;
	localparam logic [PREP_W-1:0] WIDTH_RESET = 13'd5;

	// A step this far ahead or more has already passed.
	localparam logic [31:0] LATE_LIMIT = 32'h0FFF_FFFF;

	// Result of splitting a requested period.
	typedef struct packed {
		logic [15:0] period;
		logic [27:0] excess;
	} period_t;

endpackage

`default_nettype wire

/* rtl/tsps_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none

module tsps_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* rtl/tsps_period.sv */
// Timer period splitter: a long request becomes a chunk plus excess ticks.
// Depends on tsps_pkg.
`default_nettype none

module tsps_period #(
	parameter int unsigned TIMER_MAX_COUNT = tsps_pkg::TIMER_MAX_COUNT_DEF
) (
	input  wire logic [31:0]                    req,
	input  wire logic [tsps_pkg::PREP_W-1:0]    prepare,
	output tsps_pkg::period_t                   res
);
	import tsps_pkg::*;

	localparam logic [31:0] TMAX   = 32'(TIMER_MAX_COUNT);
	localparam logic [31:0] TMAX_1 = 32'(TIMER_MAX_COUNT - 1);

	logic [31:0] lim;
	logic [31:0] chunk;
	logic [31:0] rest;

	// Chunk is the smaller of the timer range and request minus two prepares.
	assign lim   = req - {18'd0, prepare, 1'b0};
	assign chunk = (TMAX_1 > lim) ? lim : TMAX_1;
	assign rest  = req - chunk;

	always_comb begin
		if (req < TMAX) begin
			res.period = req[15:0];
			res.excess = '0;
		end else begin
			res.period = chunk[15:0];
			res.excess = rest[27:0];
		end
	end

endmodule

`default_nettype wire

/* rtl/timed_step_pulse_scheduler_unit.sv */
// Timed step pulse scheduler: top level with the step queue and sequencer.
// Depends on tsps_pkg, tsps_ram and tsps_period.
//
// Usage: items arrive on the in_* channel (valid/stall); one result per item
// leaves on the out_* channel (valid/stall). An item is transferred at a
// rising edge with valid high and stall low. Configuration registers are
// written through cfg_we/cfg_index/cfg_data while the block is idle.
// Each item has a transfer cycle, in which the queue memory read at the
// head is started and the time of the next rising edge is formed, and an
// execute cycle that uses the read data, updates the state and loads the
// output register. A new item is not taken until the execute cycle
// completes, as the read of the queue RAM is registered.
// out_valid rises when the execute cycle completes.
// The output register frees the input side: a new item is taken while a
// result waits. If the receiver stalls and a second result is ready, the
// execute cycle holds (state unchanged) until the output register empties,
// and in_stall stays high meanwhile.
// Reset clears all control state and the queue pointers at once; queue
// memory contents are not cleared and need no clearing pass.
`default_nettype none

module timed_step_pulse_scheduler_unit #(
	parameter int unsigned QUEUE_DEPTH     = tsps_pkg::QUEUE_DEPTH_DEF,
	parameter int unsigned TIMER_MAX_COUNT = tsps_pkg::TIMER_MAX_COUNT_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [tsps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [tsps_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [1:0]                     kind,
	input  wire logic [31:0]                    pulse_time,
	input  wire logic                           pulse_dir,
	input  wire logic [31:0]                    now_us,
	input  wire logic [15:0]                    timer_count,
	input  wire logic signed [31:0]             new_position,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic                                period_valid,
	output logic [15:0]                         timer_period,
	output logic                                timer_restart,
	output logic                                timer_stop,
	output logic                                step_emitted,
	output logic                                step_forced_low,
	output logic                                dir_level,
	output logic                                running,
	output logic signed [31:0]                  position,
	output logic                                push_rejected
);
	import tsps_pkg::*;

	localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned FW = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q;

	// Configuration.
	logic              dir_inv_q;
	logic [PREP_W-1:0] prep_q;
	logic [PREP_W-1:0] width_q;

	// Captured item.
	logic [1:0]  kind_s1;
	logic [31:0] ptime_s1;
	logic        pdir_s1;
	logic [31:0] edge_s1;
	logic [31:0] newpos_s1;

	// Scheduler state.
	logic [AW-1:0] head_q;
	logic [FW-1:0] fill_q;
	logic [27:0]   excess_q;
	logic          pend_dir_q, cur_dir_q, force_q, run_q;
	logic          stop_pend_q, skip_q, idle_pend_q;
	logic [31:0]   pos_q;

	logic [AW-1:0] head_d;
	logic [FW-1:0] fill_d;
	logic [27:0]   excess_d;
	logic          pend_dir_d, cur_dir_d, force_d, run_d;
	logic          stop_pend_d, skip_d, idle_pend_d;
	logic [31:0]   pos_d;

	// Result fields.
	logic        r_valid, r_restart, r_stop, r_step, r_rej;
	logic [15:0] r_period;

	logic          commit;
	logic          wr_en;
	logic [AW:0]   tail_sum;
	logic [AW-1:0] tail;
	logic [AW-1:0] head_inc;
	logic [31:0]   word;
	logic [31:0]   dt;
	logic [13:0]   near_lim;
	logic [31:0]   min_per;
	logic          dt_ok;
	logic          excess_path;
	logic [31:0]   pp_req;
	period_t       pu;

	assign in_stall = (state_q != S_IDLE);
	assign commit   = (state_q == S_EXEC) && !(out_valid && out_stall);

	// Queue memory; the head entry is read in every cycle.
	tsps_ram #(
		.WIDTH(32),
		.DEPTH(QUEUE_DEPTH),
		.AW   (AW)
	) u_queue (
		.clk  (clk),
		.we   (wr_en),
		.waddr(tail),
		.wdata({ptime_s1[31:1], pdir_s1}),
		.raddr(head_q),
		.rdata(word)
	);

	// Tail and head wrap.
	assign tail_sum = {1'b0, head_q} + (AW+1)'(fill_q);
	assign tail     = (tail_sum >= (AW+1)'(QUEUE_DEPTH)) ?
		AW'(tail_sum - (AW+1)'(QUEUE_DEPTH)) : tail_sum[AW-1:0];
	assign head_inc = (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;

	// Distance from the next rising edge to the queued step.
	assign dt       = {word[31:1], 1'b0} - edge_s1;
	assign near_lim = {1'b0, prep_q} + {1'b0, width_q} + 14'd1;
	assign min_per  = {18'd0, near_lim} + 32'd1;
	assign dt_ok    = (dt > {18'd0, near_lim}) && (dt < LATE_LIMIT);

	// The excess path is the only timer branch whose period request comes from the excess ticks.
	assign excess_path = (kind_s1 == KIND_TIMER) && run_q && !stop_pend_q &&
		!idle_pend_q && !skip_q && (excess_q != '0);
	assign pp_req = excess_path ? {4'd0, excess_q} :
		((fill_q != '0) && dt_ok) ? dt : min_per;

	tsps_period #(
		.TIMER_MAX_COUNT(TIMER_MAX_COUNT)
	) u_period (
		.req    (pp_req),
		.prepare(prep_q),
		.res    (pu)
	);

	// Item execution.
	always_comb begin
		logic do_load;
		logic halt;
		logic pp_en;
		head_d = head_q; fill_d = fill_q; excess_d = excess_q;
		pend_dir_d = pend_dir_q; cur_dir_d = cur_dir_q; force_d = force_q;
		run_d = run_q; stop_pend_d = stop_pend_q; skip_d = skip_q;
		idle_pend_d = idle_pend_q; pos_d = pos_q;
		r_valid = 1'b0; r_period = '0; r_restart = 1'b0; r_stop = 1'b0;
		r_step = 1'b0; r_rej = 1'b0; wr_en = 1'b0;
		do_load = 1'b0; halt = 1'b0; pp_en = 1'b0;
		unique case (kind_s1)
			KIND_PUSH: begin
				if (fill_q >= FW'(QUEUE_DEPTH)) begin
					r_rej = 1'b1;
				end else begin
					wr_en  = commit;
					fill_d = fill_q + 1'b1;
					if (!run_q) begin
						force_d   = 1'b1;
						skip_d    = 1'b1;
						r_valid   = 1'b1;
						r_period  = {3'd0, prep_q};
						r_restart = 1'b1;
						run_d     = 1'b1;
					end
				end
			end
			KIND_TIMER: begin
				priority if (!run_q) begin
					// Timer event while stopped is ignored.
				end else if (stop_pend_q) begin
					halt        = 1'b1;
					force_d     = 1'b1;
					stop_pend_d = 1'b0;
					idle_pend_d = 1'b0;
				end else if (idle_pend_q) begin
					idle_pend_d = 1'b0;
					force_d     = 1'b1;
					if (fill_q != '0) begin
						do_load = 1'b1;
					end else begin
						halt = 1'b1;
					end
				end else if (skip_q) begin
					skip_d  = 1'b0;
					do_load = 1'b1;
				end else if (excess_q == '0) begin
					force_d   = 1'b0;
					cur_dir_d = pend_dir_q;
					pos_d     = pend_dir_q ? pos_q + 32'd1 : pos_q - 32'd1;
					r_step    = 1'b1;
					do_load   = 1'b1;
				end else begin
					force_d = 1'b1;
					pp_en   = 1'b1;
				end
			end
			KIND_RESET: begin
				if (run_q) begin
					stop_pend_d = 1'b1;
					idle_pend_d = 1'b0;
					r_restart   = 1'b1;
				end
				excess_d = '0;
				head_d   = '0;
				fill_d   = '0;
			end
			KIND_SETPOS: begin
				pos_d = newpos_s1;
			end
			default: begin
			end
		endcase
		// Load the next queued step, or run idle when the queue is empty.
		if (do_load) begin
			pp_en = 1'b1;
			if (fill_q == '0) begin
				idle_pend_d = 1'b1;
			end else begin
				head_d     = head_inc;
				fill_d     = fill_q - 1'b1;
				pend_dir_d = word[0];
			end
		end
		if (halt) begin
			r_valid  = 1'b1;
			r_period = {4'd0, prep_q[PREP_W-1:1]};
			r_stop   = 1'b1;
			run_d    = 1'b0;
		end
		if (pp_en) begin
			r_valid  = 1'b1;
			r_period = pu.period;
			excess_d = pu.excess;
		end
	end

	// Sequencer, configuration and scheduler state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			dir_inv_q <= 1'b0; prep_q <= PREP_RESET; width_q <= WIDTH_RESET;
			head_q <= '0; fill_q <= '0; excess_q <= '0;
			pend_dir_q <= 1'b0; cur_dir_q <= 1'b0; force_q <= 1'b0; run_q <= 1'b0;
			stop_pend_q <= 1'b0; skip_q <= 1'b0; idle_pend_q <= 1'b0;
			pos_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_DIR_INV: dir_inv_q <= cfg_data[0];
					CFG_PREP:    prep_q    <= cfg_data;
					CFG_WIDTH:   width_q   <= cfg_data;
					default: begin
					end
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (commit) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (commit) begin
				head_q <= head_d; fill_q <= fill_d; excess_q <= excess_d;
				pend_dir_q <= pend_dir_d; cur_dir_q <= cur_dir_d;
				force_q <= force_d; run_q <= run_d;
				stop_pend_q <= stop_pend_d; skip_q <= skip_d;
				idle_pend_q <= idle_pend_d; pos_q <= pos_d;
			end
			if (commit) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	// Input capture on transfer; the time of the next rising edge is formed here.
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_s1   <= kind;
			ptime_s1  <= pulse_time;
			pdir_s1   <= pulse_dir;
			edge_s1   <= now_us + {19'd0, prep_q} - {16'd0, timer_count};
			newpos_s1 <= new_position;
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (commit) begin
			period_valid    <= r_valid;
			timer_period    <= r_period;
			timer_restart   <= r_restart;
			timer_stop      <= r_stop;
			step_emitted    <= r_step;
			step_forced_low <= force_d;
			dir_level       <= cur_dir_d ^ dir_inv_q;
			running         <= run_d;
			position        <= pos_d;
			push_rejected   <= r_rej;
		end
	end

endmodule

`default_nettype wire

/* rtl/tsps_checker.sv */
// Port-level checker for the timed step pulse scheduler, bound to the top.
// Depends on timed_step_pulse_scheduler_unit_macros.svh.
`default_nettype none
`include "timed_step_pulse_scheduler_unit_macros.svh"

module tsps_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic        period_valid,
	input wire logic [15:0] timer_period,
	input wire logic        timer_restart,
	input wire logic        timer_stop,
	input wire logic        step_emitted,
	input wire logic        step_forced_low,
	input wire logic        running,
	input wire logic        push_rejected
);

	// A stalled result stays offered.
	`TSPS_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped under stall")
	// No period programmed means the period field reads zero.
	`TSPS_ASSERT(a_period_zero, out_valid && !period_valid |-> timer_period == 16'd0, "stray period")
	// A released step always ends forcing of the step output.
	`TSPS_ASSERT(a_step_unforced, out_valid && step_emitted |-> !step_forced_low, "step while forced")
	// A stop programs a period and leaves the generator stopped.
	`TSPS_ASSERT(a_stop, out_valid && timer_stop |-> period_valid && !running && !step_emitted, "bad stop")
	// A rejected push has no timer effect.
	`TSPS_ASSERT_ALWAYS(a_reject, !arst_n || !(out_valid && push_rejected) || (!period_valid && !timer_restart), "reject with timer action")

endmodule

bind timed_step_pulse_scheduler_unit tsps_checker u_tsps_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.period_valid   (period_valid),
	.timer_period   (timer_period),
	.timer_restart  (timer_restart),
	.timer_stop     (timer_stop),
	.step_emitted   (step_emitted),
	.step_forced_low(step_forced_low),
	.running        (running),
	.push_rejected  (push_rejected)
);

`default_nettype wire
